// ===== design/amtg_pkg.sv =====
// shared constants, register codes and sine table builder for the am tone generator
package amtg_pkg;

    localparam int OUT_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int INDEX_W   = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_CARRIER_STEP   = 2'd0;
    localparam t_cfg_idx REG_MODULATOR_STEP = 2'd1;
    localparam t_cfg_idx REG_SAMPLE_COUNT   = 2'd2;

    // pi/2 in q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // taylor term divisor (2k)(2k+1), used only while building the table
    function automatic logic [63:0] term_div(input logic [63:0] t, input int k);
        logic [63:0] q;
        unique case (k)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            8:       q = t / 64'd272;
            default: q = t;
        endcase
        return q;
    endfunction

    // magnitude of sin(j / 2^qbits * pi/2) in q1.(sbits-1), j in [0, 2^qbits]
    function automatic int quarter_sine(input int j, input int qbits, input int sbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        lim;
        x    = (64'(j) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 8; k++) begin
            term = term_div((term * x2) >> 30, k);
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        lim = (64'd1 << (sbits - 1)) - 64'd1;
        mag = ($unsigned(sum) + (64'd1 << (30 - sbits))) >> (31 - sbits);
        if (mag > lim) begin
            mag = lim;
        end
        return int'(mag);
    endfunction

endpackage

// ===== design/am_tone_generator_top.sv =====
// top level of the amplitude-modulated tone generator
//
// usage: each transfer on the input channel (i_valid/o_ready) is one sample
// tick and yields exactly one transfer on the output channel (o_valid/i_ready)
// carrying o_sample (q1.15, within plus or minus one half) and o_done_res.
// i_restart set on a tick clears both phases and the sample counter before
// that tick's sample is made.
// the write port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the carrier step,
// the modulator step and the sample count; write only while idle.
// the transfer edge registers both sine table reads in the first stage; the
// mixer then registers the product and rounding in the output register, and
// o_valid rises when the output register is loaded.
// throughput: one tick per cycle while o_ready is high.
// once sample_count samples are out, samples are zero with o_done_res set.
// reset clears the phases, counter, config registers and stage valid flags.
// when the receiver stalls, the output register holds and the first stage
// still fills; o_ready drops only when both stages are full.
module am_tone_generator_top #(
    parameter int PHASE_BITS           = 32,
    parameter int SINE_TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS          = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  amtg_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [amtg_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [amtg_pkg::OUT_W-1:0] o_sample,
    output logic                             o_done_res
);

    logic [amtg_pkg::CFG_W-1:0]        r_carrier_step;
    logic [amtg_pkg::CFG_W-1:0]        r_modulator_step;
    logic [amtg_pkg::CFG_W-1:0]        r_sample_count;

    logic                              r_s1_valid;
    logic signed [SAMPLE_BITS-1:0]     r_s1_carrier;
    logic signed [SAMPLE_BITS-1:0]     r_s1_modulator;
    logic                              r_s1_active;

    logic                              w_accept;
    logic                              w_s2_ready;
    logic [SINE_TABLE_ADDR_BITS-1:0]   w_carrier_addr;
    logic [SINE_TABLE_ADDR_BITS-1:0]   w_modulator_addr;
    logic                              w_active;
    logic signed [SAMPLE_BITS-1:0]     w_carrier_sine;
    logic signed [SAMPLE_BITS-1:0]     w_modulator_sine;
    logic [amtg_pkg::OUT_W-1:0]        w_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step   <= '0;
            r_modulator_step <= '0;
            r_sample_count   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                amtg_pkg::REG_CARRIER_STEP:   r_carrier_step   <= i_cfg_data;
                amtg_pkg::REG_MODULATOR_STEP: r_modulator_step <= i_cfg_data;
                amtg_pkg::REG_SAMPLE_COUNT:   r_sample_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready  = !r_s1_valid || w_s2_ready;
    assign w_accept = i_valid && o_ready;

    amtg_phase #(
        .PHASE_BITS (PHASE_BITS),
        .ADDR_BITS  (SINE_TABLE_ADDR_BITS)
    ) u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_accept),
        .i_restart        (i_restart),
        .i_carrier_step   (r_carrier_step),
        .i_modulator_step (r_modulator_step),
        .i_sample_count   (r_sample_count),
        .o_carrier_addr   (w_carrier_addr),
        .o_modulator_addr (w_modulator_addr),
        .o_active         (w_active)
    );

    amtg_sine_lookup #(
        .ADDR_BITS   (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_carrier_sine (
        .i_addr  (w_carrier_addr),
        .o_value (w_carrier_sine)
    );

    amtg_sine_lookup #(
        .ADDR_BITS   (SINE_TABLE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_modulator_sine (
        .i_addr  (w_modulator_addr),
        .o_value (w_modulator_sine)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_carrier   <= w_carrier_sine;
            r_s1_modulator <= w_modulator_sine;
            r_s1_active    <= w_active;
        end
    end

    amtg_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .o_ready     (w_s2_ready),
        .i_carrier   (r_s1_carrier),
        .i_modulator (r_s1_modulator),
        .i_active    (r_s1_active),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (w_sample),
        .o_done_res  (o_done_res)
    );

    assign o_sample = $signed(w_sample);

    // silence after the tone ends
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_sample == '0))
        else $error("done sample is not silent");

    // with a zero count every tick is done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_sample_count == '0)) |-> o_done_res)
        else $error("sample emitted with zero count");

    // restart with a nonzero count always starts the tone
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart && (r_sample_count != '0)) |=> (r_s1_valid && r_s1_active))
        else $error("restart did not start the tone");

endmodule

// ===== design/amtg_sine_lookup.sv =====
// quarter-wave sine table lookup, full-circle address to signed sample
module amtg_sine_lookup #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic [ADDR_BITS-1:0]          i_addr,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int QBITS = ADDR_BITS - 2;
    localparam int QLEN  = 1 << QBITS;

    typedef logic [SAMPLE_BITS-2:0] t_mag;
    typedef t_mag t_qtab [QLEN];

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int j = 0; j < QLEN; j++) begin
            tab[j] = t_mag'(amtg_pkg::quarter_sine(j, QBITS, SAMPLE_BITS));
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();
    localparam t_mag  PEAK = t_mag'(amtg_pkg::quarter_sine(QLEN, QBITS, SAMPLE_BITS));

    logic [1:0]       w_quad;
    logic [QBITS-1:0] w_j;
    logic [QBITS-1:0] w_tidx;
    logic             w_peak;
    t_mag             w_mag;

    assign w_quad = i_addr[ADDR_BITS-1 -: 2];
    assign w_j    = i_addr[QBITS-1:0];

    // odd quadrants run backwards; their first entry is the crest
    assign w_tidx = w_quad[0] ? (QBITS'(0) - w_j) : w_j;
    assign w_peak = w_quad[0] && (w_j == '0);
    assign w_mag  = w_peak ? PEAK : QTAB[w_tidx];

    assign o_value = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

endmodule

// ===== design/amtg_phase.sv =====
// carrier and modulator phase accumulators with the sample index
module amtg_phase #(
    parameter int PHASE_BITS = 32,
    parameter int ADDR_BITS  = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_restart,
    input  logic [amtg_pkg::CFG_W-1:0]   i_carrier_step,
    input  logic [amtg_pkg::CFG_W-1:0]   i_modulator_step,
    input  logic [amtg_pkg::CFG_W-1:0]   i_sample_count,
    output logic [ADDR_BITS-1:0]         o_carrier_addr,
    output logic [ADDR_BITS-1:0]         o_modulator_addr,
    output logic                         o_active
);

    logic [PHASE_BITS-1:0]            r_carrier_phase;
    logic [PHASE_BITS-1:0]            r_modulator_phase;
    logic [amtg_pkg::INDEX_W-1:0]     r_index;
    logic [PHASE_BITS-1:0]            n_carrier_phase;
    logic [PHASE_BITS-1:0]            n_modulator_phase;
    logic [amtg_pkg::INDEX_W-1:0]     n_index;

    logic [PHASE_BITS+amtg_pkg::CFG_W-1:0] w_c_ext;
    logic [PHASE_BITS+amtg_pkg::CFG_W-1:0] w_m_ext;
    logic [PHASE_BITS-1:0]            w_c_step;
    logic [PHASE_BITS-1:0]            w_m_step;
    logic [PHASE_BITS-1:0]            w_c_phase;
    logic [PHASE_BITS-1:0]            w_m_phase;
    logic [amtg_pkg::INDEX_W-1:0]     w_index;

    // steps wider than the phase are truncated
    assign w_c_ext  = {{PHASE_BITS{1'b0}}, i_carrier_step};
    assign w_m_ext  = {{PHASE_BITS{1'b0}}, i_modulator_step};
    assign w_c_step = w_c_ext[PHASE_BITS-1:0];
    assign w_m_step = w_m_ext[PHASE_BITS-1:0];

    assign w_c_phase = i_restart ? '0 : r_carrier_phase;
    assign w_m_phase = i_restart ? '0 : r_modulator_phase;
    assign w_index   = i_restart ? '0 : r_index;

    assign o_active         = w_index < i_sample_count;
    assign o_carrier_addr   = w_c_phase[PHASE_BITS-1 -: ADDR_BITS];
    assign o_modulator_addr = w_m_phase[PHASE_BITS-1 -: ADDR_BITS];

    always_comb begin
        n_carrier_phase   = w_c_phase;
        n_modulator_phase = w_m_phase;
        n_index           = w_index;
        if (o_active) begin
            n_carrier_phase   = w_c_phase + w_c_step;
            n_modulator_phase = w_m_phase + w_m_step;
            n_index           = w_index + amtg_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase   <= '0;
            r_modulator_phase <= '0;
            r_index           <= '0;
        end else if (i_advance) begin
            r_carrier_phase   <= n_carrier_phase;
            r_modulator_phase <= n_modulator_phase;
            r_index           <= n_index;
        end
    end

endmodule

// ===== design/amtg_mixer.sv =====
// modulation product with rounding and the output register
module amtg_mixer #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_carrier,
    input  logic signed [SAMPLE_BITS-1:0]    i_modulator,
    input  logic                             i_active,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [amtg_pkg::OUT_W-1:0]       o_sample,
    output logic                             o_done_res
);

    localparam int PW = 2 * SAMPLE_BITS + 2;
    localparam logic signed [PW-1:0] SCALE = PW'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [PW-1:0] ROUND = PW'(1) << SAMPLE_BITS;

    logic                          r_valid;
    logic [amtg_pkg::OUT_W-1:0]    r_sample;
    logic                          r_done;
    logic signed [PW-1:0]          w_prod;
    logic signed [PW-1:0]          w_shift;
    logic [amtg_pkg::OUT_W-1:0]    n_sample;

    // floor((tc * (S + tm) + 2S) / 4S)
    assign w_prod   = PW'(i_carrier) * (SCALE + PW'(i_modulator));
    assign w_shift  = (w_prod + ROUND) >>> (SAMPLE_BITS + 1);
    assign n_sample = i_active ? w_shift[amtg_pkg::OUT_W-1:0] : '0;

    assign o_ready    = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;
    assign o_done_res = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= n_sample;
            r_done   <= !i_active;
        end
    end

endmodule
